// ===== sv/tka_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tuning knob accelerator package
// Beat types, register indexes, event codes and the step size table.
// ----------------------------------------------------------------------------
package tka_pkg;

    localparam int FREQ_BITS_DEF  = 24;
    localparam int TICK_LIMIT_DEF = 500;

    localparam int FREQ_OUT_W  = 24;
    localparam int LOAD_W      = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int WINDOW_W    = 9;
    localparam int RUN_W       = 16;
    localparam int STEP_W      = 10;

    localparam int TICK_RESET = 255;

    localparam logic [1:0]       MODE_RESET     = 2'd0;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 9'd30;
    localparam logic [RUN_W-1:0] MID_RESET      = 16'd150;
    localparam logic [RUN_W-1:0] FAST_RESET     = 16'd500;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TUNING_MODE    = 2'd0,
        CFG_FAST_WINDOW    = 2'd1,
        CFG_MID_THRESHOLD  = 2'd2,
        CFG_FAST_THRESHOLD = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        EVT_TICK = 2'd0,
        EVT_UP   = 2'd1,
        EVT_DOWN = 2'd2,
        EVT_LOAD = 2'd3
    } evt_kind_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        MODE_SSB = 2'd0,
        MODE_AM  = 2'd1,
        MODE_FM  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STEP_SMALL  = 2'd0,
        STEP_MEDIUM = 2'd1,
        STEP_LARGE  = 2'd2
    } step_size_t;

    typedef struct packed {
        logic [1:0]        event_kind;
        logic [LOAD_W-1:0] load_value;
    } in_beat_t;

    typedef struct packed {
        logic [FREQ_OUT_W-1:0] frequency;
        logic                  changed;
    } out_beat_t;

    // Step in 50 Hz units; the unused mode code falls back to the fine steps.
    function automatic logic [STEP_W-1:0] step_lookup(input logic [1:0] mode,
                                                      input logic [1:0] size);
        logic [STEP_W-1:0] s;
        case (mode)
            MODE_AM: begin
                case (size)
                    STEP_LARGE:  s = 10'd400;
                    STEP_MEDIUM: s = 10'd100;
                    default:     s = 10'd20;
                endcase
            end
            MODE_FM: begin
                case (size)
                    STEP_LARGE:  s = 10'd1000;
                    STEP_MEDIUM: s = 10'd500;
                    default:     s = 10'd50;
                endcase
            end
            default: begin
                case (size)
                    STEP_LARGE:  s = 10'd20;
                    STEP_MEDIUM: s = 10'd10;
                    default:     s = 10'd1;
                endcase
            end
        endcase
        return s;
    endfunction

endpackage

// ===== sv/tuning_knob_accelerator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tuning knob accelerator
// Rotary encoder tuning with speed dependent step size and saturating
// frequency, kept in 50 Hz units.
// ----------------------------------------------------------------------------
// Usage:
// Events arrive as beats on the s_ channel (tick, up detent, down detent or
// load). Every event yields exactly one result beat on the m_ channel with
// the frequency after the event and a flag telling whether it changed.
// Registers are to be written through cfg_we, cfg_index and cfg_wdata only
// while the block is idle; the block itself does not enforce this. A write
// takes effect at the clock edge it is presented. An input beat passes
// through the input register, then through the update logic into the result
// register. Throughput is one beat per cycle while the receiver does not
// stall, set by the state update between those two registers.
// When the receiver stalls, the result register holds its beat and the
// input register still takes one more beat before s_ready drops.
// Reset (aresetn low at a clock edge) empties both registers and restores the
// register defaults, the tick timer to 255 and the frequency to zero.
// ----------------------------------------------------------------------------
module tuning_knob_accelerator_unit #(
    parameter int FREQ_BITS  = tka_pkg::FREQ_BITS_DEF,
    parameter int TICK_LIMIT = tka_pkg::TICK_LIMIT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  tka_pkg::in_beat_t                s_beat,
    output logic                             m_valid,
    input  logic                             m_ready,
    output tka_pkg::out_beat_t               m_beat,
    input  logic                             cfg_we,
    input  logic [tka_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tka_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int TICK_BITS = $clog2(TICK_LIMIT + 1);
    localparam int TICK_W    = (TICK_BITS > tka_pkg::WINDOW_W) ? TICK_BITS
                                                               : tka_pkg::WINDOW_W;
    localparam int WIDE_W    = FREQ_BITS + tka_pkg::FREQ_OUT_W;
    localparam int RUN_W     = tka_pkg::RUN_W;

    logic [1:0]                     mode_reg;
    logic [tka_pkg::WINDOW_W-1:0]   window_reg;
    logic [RUN_W-1:0]               mid_thr_reg;
    logic [RUN_W-1:0]               fast_thr_reg;

    logic [TICK_W-1:0]              tick_reg,  tick_next;
    logic [1:0]                     dir_reg,   dir_next;
    logic [RUN_W-1:0]               run_reg,   run_next;
    logic [FREQ_BITS-1:0]           freq_reg,  freq_next;

    logic                           in_valid_reg;
    tka_pkg::in_beat_t              in_beat_reg;
    logic                           out_valid_reg;
    tka_pkg::out_beat_t             out_beat_reg, out_beat_next;

    logic                           advance;
    logic [1:0]                     kind;
    logic [RUN_W-1:0]               run_cont;
    logic [1:0]                     size;
    logic [tka_pkg::STEP_W-1:0]     step;
    logic [FREQ_BITS-1:0]           step_ext;
    logic [FREQ_BITS:0]             up_sum;
    logic [FREQ_BITS-1:0]           up_freq;
    logic [FREQ_BITS-1:0]           down_freq;
    logic [WIDE_W-1:0]              load_wide;
    logic [WIDE_W-1:0]              freq_wide;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_beat  = out_beat_reg;

    assign kind = in_beat_reg.event_kind;

    always_comb begin
        if (tick_reg < TICK_W'(window_reg)) begin
            run_cont = (run_reg == '1) ? run_reg : run_reg + RUN_W'(1);
        end else begin
            run_cont = RUN_W'(1);
        end
        if (run_cont > fast_thr_reg) begin
            size = tka_pkg::STEP_LARGE;
        end else if (run_cont > mid_thr_reg) begin
            size = tka_pkg::STEP_MEDIUM;
        end else begin
            size = tka_pkg::STEP_SMALL;
        end
    end

    assign step      = tka_pkg::step_lookup(mode_reg, size);
    assign step_ext  = FREQ_BITS'(step);
    assign up_sum    = {1'b0, freq_reg} + {1'b0, step_ext};
    assign up_freq   = up_sum[FREQ_BITS] ? '1 : up_sum[FREQ_BITS-1:0];
    assign down_freq = (freq_reg < step_ext) ? '0 : freq_reg - step_ext;
    assign load_wide = WIDE_W'(in_beat_reg.load_value);

    always_comb begin
        tick_next = tick_reg;
        dir_next  = dir_reg;
        run_next  = run_reg;
        freq_next = freq_reg;
        case (kind)
            tka_pkg::EVT_TICK: begin
                if (tick_reg < TICK_W'(TICK_LIMIT)) begin
                    tick_next = tick_reg + TICK_W'(1);
                end
            end
            tka_pkg::EVT_UP, tka_pkg::EVT_DOWN: begin
                tick_next = '0;
                if (kind != dir_reg) begin
                    run_next = '0;
                    dir_next = kind;
                end else begin
                    run_next  = run_cont;
                    freq_next = (kind == tka_pkg::EVT_UP) ? up_freq : down_freq;
                end
            end
            tka_pkg::EVT_LOAD: begin
                freq_next = load_wide[FREQ_BITS-1:0];
            end
            default: begin
                freq_next = freq_reg;
            end
        endcase
    end

    assign freq_wide = WIDE_W'(freq_next);

    always_comb begin
        out_beat_next.frequency = freq_wide[tka_pkg::FREQ_OUT_W-1:0];
        out_beat_next.changed   = (freq_next != freq_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= tka_pkg::MODE_RESET;
            window_reg   <= tka_pkg::WINDOW_RESET;
            mid_thr_reg  <= tka_pkg::MID_RESET;
            fast_thr_reg <= tka_pkg::FAST_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                tka_pkg::CFG_TUNING_MODE:    mode_reg     <= cfg_wdata[1:0];
                tka_pkg::CFG_FAST_WINDOW:    window_reg   <= cfg_wdata[tka_pkg::WINDOW_W-1:0];
                tka_pkg::CFG_MID_THRESHOLD:  mid_thr_reg  <= cfg_wdata;
                tka_pkg::CFG_FAST_THRESHOLD: fast_thr_reg <= cfg_wdata;
                default:                     mode_reg     <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= TICK_W'(tka_pkg::TICK_RESET);
            dir_reg  <= tka_pkg::DIR_NONE;
            run_reg  <= '0;
            freq_reg <= '0;
        end else if (advance) begin
            tick_reg <= tick_next;
            dir_reg  <= dir_next;
            run_reg  <= run_next;
            freq_reg <= freq_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_beat_reg <= s_beat;
        end
        if (advance) begin
            out_beat_reg <= out_beat_next;
        end
    end

endmodule

// ===== sv/tka_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tuning knob accelerator checker
// Port level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module tka_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input tka_pkg::out_beat_t               m_beat
);

    logic [tka_pkg::FREQ_OUT_W-1:0] last_freq_reg;

    // The frequency of the last delivered beat, zero after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_freq_reg <= '0;
        end else if (m_valid && m_ready) begin
            last_freq_reg <= m_beat.frequency;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_beat))
        else $error("result beat dropped or altered while stalled");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input not ready while result side is empty");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |-> ##2 m_valid)
        else $error("accepted beat did not reach the result side in two cycles");

    a_unchanged: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_beat.changed |-> m_beat.frequency == last_freq_reg)
        else $error("frequency moved on a beat flagged unchanged");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind tuning_knob_accelerator_unit tka_checker u_tka_checker (.*);

// ===== sim/tuning_knob_accelerator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tuning knob accelerator checker
// Watches the event, result and register ports of the tuning knob block.
// It keeps its own copy of the knob state, works out the tuned frequency
// for every accepted event beat, and compares each result beat in order.
// ----------------------------------------------------------------------------
module tuning_knob_accelerator_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  tka_pkg::in_beat_t               s_beat,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  tka_pkg::out_beat_t              m_beat,
    input  logic                            cfg_we,
    input  logic [tka_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tka_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                              mismatches,
    output int                              tunes_pending,
    output int                              tunes_checked,
    output int                              medium_steps,
    output int                              large_steps
);

    localparam int TICK_LIMIT = tka_pkg::TICK_LIMIT_DEF;
    localparam int WINDOW_W   = tka_pkg::WINDOW_W;
    localparam int RUN_W      = tka_pkg::RUN_W;
    localparam int FREQ_OUT_W = tka_pkg::FREQ_OUT_W;
    localparam int STEP_W     = tka_pkg::STEP_W;

    logic [1:0]            mode_q;
    logic [WINDOW_W-1:0]   window_q;
    logic [RUN_W-1:0]      mid_q;
    logic [RUN_W-1:0]      fast_q;

    logic [WINDOW_W-1:0]   tick_q;
    tka_pkg::dir_t         dir_q;
    logic [RUN_W-1:0]      run_q;
    logic [FREQ_OUT_W-1:0] freq_q;

    tka_pkg::out_beat_t    pending_tunes [$];
    tka_pkg::out_beat_t    want;

    function automatic logic [STEP_W-1:0] step_units(input logic [1:0] mode,
                                                     input tka_pkg::step_size_t size);
        logic [STEP_W-1:0] fine;
        logic [STEP_W-1:0] mid;
        logic [STEP_W-1:0] coarse;
        if (mode == tka_pkg::MODE_FM) begin
            fine = 10'd50;
            mid = 10'd500;
            coarse = 10'd1000;
        end else if (mode == tka_pkg::MODE_AM) begin
            fine = 10'd20;
            mid = 10'd100;
            coarse = 10'd400;
        end else begin
            fine = 10'd1;
            mid = 10'd10;
            coarse = 10'd20;
        end
        if (size == tka_pkg::STEP_LARGE) begin
            return coarse;
        end
        return (size == tka_pkg::STEP_MEDIUM) ? mid : fine;
    endfunction

    // Applies one event to the local knob state and returns the result beat.
    function automatic tka_pkg::out_beat_t tune_by_event(input tka_pkg::in_beat_t b);
        tka_pkg::out_beat_t    r;
        logic [FREQ_OUT_W-1:0] prev_freq;
        logic [STEP_W-1:0]     step;
        logic [FREQ_OUT_W:0]   sum;
        tka_pkg::step_size_t   size;
        prev_freq = freq_q;
        case (tka_pkg::evt_kind_t'(b.event_kind))
            tka_pkg::EVT_TICK: begin
                if (tick_q < TICK_LIMIT) begin
                    tick_q = tick_q + 1'b1;
                end
            end
            tka_pkg::EVT_LOAD: begin
                freq_q = b.load_value;
            end
            default: begin
                if (b.event_kind != dir_q) begin
                    run_q = '0;
                    tick_q = '0;
                    dir_q = tka_pkg::dir_t'(b.event_kind);
                end else begin
                    if (tick_q < window_q) begin
                        if (run_q != {RUN_W{1'b1}}) begin
                            run_q = run_q + 1'b1;
                        end
                    end else begin
                        run_q = RUN_W'(1);
                    end
                    tick_q = '0;
                    if (run_q > fast_q) begin
                        size = tka_pkg::STEP_LARGE;
                        large_steps++;
                    end else if (run_q > mid_q) begin
                        size = tka_pkg::STEP_MEDIUM;
                        medium_steps++;
                    end else begin
                        size = tka_pkg::STEP_SMALL;
                    end
                    step = step_units(mode_q, size);
                    if (dir_q == tka_pkg::DIR_UP) begin
                        sum = {1'b0, freq_q} + step;
                        freq_q = sum[FREQ_OUT_W] ? {FREQ_OUT_W{1'b1}} : sum[FREQ_OUT_W-1:0];
                    end else begin
                        freq_q = (freq_q < step) ? '0 : freq_q - step;
                    end
                end
            end
        endcase
        r.frequency = freq_q;
        r.changed = (freq_q != prev_freq);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                 exp_val);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            mode_q = tka_pkg::MODE_RESET;
            window_q = tka_pkg::WINDOW_RESET;
            mid_q = tka_pkg::MID_RESET;
            fast_q = tka_pkg::FAST_RESET;
            tick_q = WINDOW_W'(tka_pkg::TICK_RESET);
            dir_q = tka_pkg::DIR_NONE;
            run_q = '0;
            freq_q = '0;
            pending_tunes.delete();
        end else begin
            if (cfg_we) begin
                case (tka_pkg::cfg_index_t'(cfg_index))
                    tka_pkg::CFG_TUNING_MODE:    mode_q = cfg_wdata[1:0];
                    tka_pkg::CFG_FAST_WINDOW:    window_q = cfg_wdata[WINDOW_W-1:0];
                    tka_pkg::CFG_MID_THRESHOLD:  mid_q = cfg_wdata;
                    tka_pkg::CFG_FAST_THRESHOLD: fast_q = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (pending_tunes.size() == 0) begin
                    report_mismatch("result beat with nothing expected",
                                    {7'd0, m_beat.frequency, m_beat.changed}, 32'd0);
                end else begin
                    want = pending_tunes.pop_front();
                    tunes_checked++;
                    if (m_beat.frequency !== want.frequency) begin
                        report_mismatch("frequency", {8'd0, m_beat.frequency},
                                        {8'd0, want.frequency});
                    end
                    if (m_beat.changed !== want.changed) begin
                        report_mismatch("changed", {31'd0, m_beat.changed},
                                        {31'd0, want.changed});
                    end
                end
            end
            if (s_valid && s_ready) begin
                pending_tunes.push_back(tune_by_event(s_beat));
            end
        end
        tunes_pending <= pending_tunes.size();
    end

endmodule

// ===== sim/tuning_knob_accelerator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tuning knob accelerator testbench
// Drives tick, detent and load events into the tuning knob block under a
// series of register settings, with random idling on both channels, and
// lets the checker predict and compare every result beat.
// ----------------------------------------------------------------------------
module tuning_knob_accelerator_unit_tb;

    localparam int         CYCLE_LIMIT = 400000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         TICK_RUN    = 510;
    localparam int         LOAD_W      = tka_pkg::LOAD_W;
    localparam int         WINDOW_W    = tka_pkg::WINDOW_W;
    localparam int         RUN_W       = tka_pkg::RUN_W;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    tka_pkg::in_beat_t               s_beat;
    logic                            m_valid;
    logic                            m_ready;
    tka_pkg::out_beat_t              m_beat;
    logic                            cfg_we;
    logic [tka_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [tka_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    int mismatches;
    int tunes_pending;
    int tunes_checked;
    int medium_steps;
    int large_steps;
    int cycle_count;
    int events_sent;
    int events_by_kind [4];
    int window_now;
    bit send_steady;
    bit take_steady;

    tuning_knob_accelerator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_beat    (s_beat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_beat    (m_beat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    tuning_knob_accelerator_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_beat        (s_beat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_beat        (m_beat),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .tunes_pending (tunes_pending),
        .tunes_checked (tunes_checked),
        .medium_steps  (medium_steps),
        .large_steps   (large_steps)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("run stopped after %0d cycles with %0d results still owed", cycle_count,
                 tunes_pending);
        $display("end of test: mismatches");
        $finish;
    end

    // Result side: a random stall before each beat, or none while steady.
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = take_steady ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    function automatic logic [LOAD_W-1:0] rand_load();
        logic [31:0] w;
        w = $urandom();
        return w[LOAD_W-1:0];
    endfunction

    // Loads cluster near both ends of the range so that steps saturate often.
    function automatic logic [LOAD_W-1:0] pick_load();
        logic [31:0] w;
        case ($urandom_range(0, 3))
            0: w = 32'h00FF_FFFF - $urandom_range(0, 1500);
            1: w = $urandom_range(0, 1500);
            default: w = $urandom();
        endcase
        return w[LOAD_W-1:0];
    endfunction

    // Ticks placed before a detent: mostly inside the window, sometimes
    // right at its edge or just past it.
    function automatic int pick_ticks();
        int r;
        r = $urandom_range(0, 99);
        if (window_now == 0) begin
            return $urandom_range(0, 2);
        end
        if (window_now <= 40 && r < 4) begin
            return $urandom_range(window_now, window_now + 2);
        end
        if (window_now <= 40 && r < 8) begin
            return window_now - 1;
        end
        return $urandom_range(0, (window_now - 1 < 3) ? window_now - 1 : 3);
    endfunction

    task automatic pick_idling();
        send_steady = ($urandom_range(0, 3) == 0);
        take_steady = ($urandom_range(0, 3) == 0);
    endtask

    task automatic send_event(input tka_pkg::evt_kind_t kind,
                              input logic [LOAD_W-1:0] value);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_beat <= '{event_kind: kind, load_value: value};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        events_sent++;
        events_by_kind[kind]++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tunes_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_settings(input logic [1:0] mode, input logic [WINDOW_W-1:0] window,
                                 input logic [RUN_W-1:0] mid, input logic [RUN_W-1:0] fast,
                                 input bit junk);
        logic [31:0] w;
        w = junk ? $urandom() : 32'd0;
        cfg_we <= 1'b1;
        cfg_index <= tka_pkg::CFG_TUNING_MODE;
        cfg_wdata <= {w[15:2], mode};
        @(posedge aclk);
        cfg_index <= tka_pkg::CFG_FAST_WINDOW;
        cfg_wdata <= {w[22:16], window};
        @(posedge aclk);
        cfg_index <= tka_pkg::CFG_MID_THRESHOLD;
        cfg_wdata <= mid;
        @(posedge aclk);
        cfg_index <= tka_pkg::CFG_FAST_THRESHOLD;
        cfg_wdata <= fast;
        @(posedge aclk);
        cfg_we <= 1'b0;
        window_now = int'(window);
        pick_idling();
    endtask

    task automatic random_traffic(input int budget);
        int                 sent_here;
        int                 r;
        int                 ticks;
        int                 n;
        tka_pkg::evt_kind_t dir;
        sent_here = 0;
        while (sent_here < budget) begin
            if ($urandom_range(0, 19) == 0) begin
                pick_idling();
            end
            r = $urandom_range(0, 99);
            if (r < 65) begin
                dir = ($urandom_range(0, 1) == 1) ? tka_pkg::EVT_UP : tka_pkg::EVT_DOWN;
                repeat ($urandom_range(1, 24)) begin
                    ticks = pick_ticks();
                    repeat (ticks) send_event(tka_pkg::EVT_TICK, rand_load());
                    send_event(dir, rand_load());
                    sent_here += ticks + 1;
                end
            end else if (r < 82) begin
                send_event(tka_pkg::EVT_LOAD, pick_load());
                sent_here++;
            end else if (r < 94) begin
                send_event(tka_pkg::evt_kind_t'($urandom_range(0, 3)), rand_load());
                sent_here++;
            end else begin
                n = $urandom_range(1, 40);
                repeat (n) send_event(tka_pkg::EVT_TICK, rand_load());
                sent_here += n;
            end
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_beat <= '0;
        m_ready <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= tka_pkg::CFG_TUNING_MODE;
        cfg_wdata <= '0;
        events_sent = 0;
        window_now = int'(tka_pkg::WINDOW_RESET);
        send_steady = 1'b0;
        take_steady = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: first direction, saturation at both ends, repeated
        // loads that leave the frequency alone, and direction reversals.
        send_event(tka_pkg::EVT_TICK, 24'h000000);
        send_event(tka_pkg::EVT_DOWN, 24'hFFFFFF);
        send_event(tka_pkg::EVT_DOWN, 24'h000000);
        send_event(tka_pkg::EVT_LOAD, 24'hFFFFFF);
        send_event(tka_pkg::EVT_LOAD, 24'hFFFFFF);
        send_event(tka_pkg::EVT_UP, 24'h000000);
        send_event(tka_pkg::EVT_UP, 24'hFFFFFF);
        send_event(tka_pkg::EVT_LOAD, 24'hFFFFFE);
        send_event(tka_pkg::EVT_UP, 24'h000000);
        send_event(tka_pkg::EVT_LOAD, 24'h000000);
        send_event(tka_pkg::EVT_UP, 24'h555555);
        send_event(tka_pkg::EVT_DOWN, 24'hAAAAAA);
        send_event(tka_pkg::EVT_DOWN, 24'h555555);
        send_event(tka_pkg::EVT_LOAD, 24'hAAAAAA);
        send_event(tka_pkg::EVT_LOAD, 24'h555555);
        send_event(tka_pkg::EVT_UP, 24'h000000);
        send_event(tka_pkg::EVT_UP, 24'hFFFFFF);
        send_event(tka_pkg::EVT_TICK, 24'hFFFFFF);
        send_event(tka_pkg::EVT_UP, 24'h000000);
        send_event(tka_pkg::EVT_DOWN, 24'h000000);
        send_event(tka_pkg::EVT_TICK, 24'h000000);
        send_event(tka_pkg::EVT_LOAD, 24'h000001);
        send_event(tka_pkg::EVT_DOWN, 24'h000000);
        send_event(tka_pkg::EVT_DOWN, 24'h000000);
        settle();

        load_settings(tka_pkg::MODE_SSB, 9'd30, 16'd2, 16'd6, 1'b0);
        random_traffic(75);
        settle();

        // The widest window with a timer held at its limit still continues
        // the run.
        load_settings(tka_pkg::MODE_AM, 9'd511, 16'd3, 16'd10, 1'b0);
        send_event(tka_pkg::EVT_UP, rand_load());
        repeat (TICK_RUN) send_event(tka_pkg::EVT_TICK, rand_load());
        send_event(tka_pkg::EVT_UP, rand_load());
        random_traffic(75);
        settle();

        load_settings(tka_pkg::MODE_FM, 9'd8, 16'd1, 16'd4, 1'b1);
        random_traffic(75);
        settle();

        load_settings(MODE_UNUSED, 9'd0, 16'd0, 16'd0, 1'b0);
        random_traffic(75);
        settle();

        load_settings(tka_pkg::MODE_AM, 9'd20, 16'hFFFF, 16'hFFFF, 1'b1);
        random_traffic(75);
        settle();

        load_settings(tka_pkg::MODE_FM, 9'd100, 16'd0, 16'hFFFF, 1'b0);
        random_traffic(75);
        settle();

        load_settings(tka_pkg::MODE_SSB, 9'd5, 16'd4, 16'd12, 1'b1);
        random_traffic(75);
        settle();

        $display("Covered %0d events (%0d ticks, %0d up, %0d down, %0d loads) over %0s",
                 events_sent, events_by_kind[tka_pkg::EVT_TICK],
                 events_by_kind[tka_pkg::EVT_UP], events_by_kind[tka_pkg::EVT_DOWN],
                 events_by_kind[tka_pkg::EVT_LOAD],
                 "reset values and seven register settings.");
        $display("Checked %0d result beats; %0d medium and %0d large steps were predicted.",
                 tunes_checked, medium_steps, large_steps);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
